[rtl/core/lruk_pkg.sv]
// Package for the LRU-K frame replacer: command codes, status codes, sequencer states.
// No dependencies.
package lruk_pkg;
	localparam int TS_W = 48;

	typedef enum logic [1:0] {
		CMD_ACCESS = 2'd0,
		CMD_SET_EVICT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_EVICT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_EVICTABLE = 2'd1,
		ST_NO_VICTIM = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DONE
	} state_t;
endpackage

[rtl/core/lruk_if.sv]
// Valid/ready channel interfaces for the LRU-K frame replacer.
// Depends on nothing.
interface lruk_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [5:0] frame;
	logic evictable_flag;
	modport source (output valid, cmd, frame, evictable_flag, input ready);
	modport sink (input valid, cmd, frame, evictable_flag, output ready);
endinterface

interface lruk_out_if;
	logic valid;
	logic ready;
	logic victim_valid;
	logic [5:0] chosen_frame;
	logic [1:0] status;
	logic [6:0] evictable_count;
	modport source (output valid, victim_valid, chosen_frame, status, evictable_count,
		input ready);
	modport sink (input valid, victim_valid, chosen_frame, status, evictable_count,
		output ready);
endinterface

[rtl/core/lru_k_frame_replacer.sv]
// LRU-K frame replacer top level: sequencer, per-frame state, history memory, shared
// age subtract/compare unit. Depends on lruk_pkg and lruk_if.
//
// Usage: words arrive on in_ch (cmd, frame, evictable_flag); one result word per input
// word leaves on out_ch. history_depth is written through cfg_we/cfg_data while idle.
// The block itself does not enforce this. Set evictable, remove and an access to a
// frame below k entries pass through S_SHIFT_RD straight to S_DONE. An access
// to a full history shifts each kept entry down with one memory read and one write.
// An evict takes each frame in turn: one history and count read, then one pass
// through the shared age subtract and compare.
// The next word can be accepted in the cycle after the result handshake.
// The history memory serves one read per cycle.
// One word is worked on at a time; in_ch.ready is low from acceptance until the
// result is taken. A stalled receiver holds the result in the output register.
// Reset clears tracking, evictable marks, counts, the access clock and sets k to 2;
// the history memory is not cleared and needs no clearing pass.
module lru_k_frame_replacer
	import lruk_pkg::*;
#(
	parameter int FRAME_COUNT = 64,
	parameter int MAX_HISTORY = 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [3:0] cfg_data,
	lruk_in_if.sink in_ch,
	lruk_out_if.source out_ch
);
	localparam int FW = $clog2(FRAME_COUNT);
	localparam int HW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	localparam int CW = $clog2(MAX_HISTORY + 1);

	state_t state_q, state_d;
	logic [3:0] depth_q;
	logic [FRAME_COUNT-1:0] tracked_q, evict_q;
	logic [CW-1:0] cnt_q [FRAME_COUNT];
	logic [CW-1:0] cnt_rd_q;
	logic [TS_W-1:0] clock_q;
	logic [6:0] total_q;
	logic [TS_W-1:0] hist_mem [FRAME_COUNT*MAX_HISTORY];
	logic [TS_W-1:0] rd_q;

	logic [1:0] cmd_q;
	logic [5:0] frame_in_q;
	logic flag_q;
	logic [FW:0] idx_q;
	logic [HW:0] pos_q;
	logic found_q, found_inf_q;
	logic [TS_W-1:0] best_q;
	logic [FW-1:0] best_f_q;
	logic res_vv_q;
	logic [5:0] res_vf_q;
	logic [1:0] res_st_q;

	logic [CW-1:0] k_used;
	always_comb begin
		if (depth_q == 4'd0) k_used = CW'(1);
		else if (32'(depth_q) > MAX_HISTORY) k_used = CW'(MAX_HISTORY);
		else k_used = CW'(depth_q);
	end

	logic in_range;
	logic [FW-1:0] fidx;
	assign in_range = 32'(frame_in_q) < FRAME_COUNT;
	assign fidx = FW'(frame_in_q);

	logic [FW-1:0] sidx;
	assign sidx = idx_q[FW-1:0];

	// shared unit: age of scanned frame and compare with best
	logic [TS_W-1:0] age;
	logic age_gt, s_inf, s_elig, s_take;
	assign age = clock_q - rd_q;
	assign age_gt = age > best_q;
	assign s_elig = tracked_q[sidx] && evict_q[sidx];
	assign s_inf = cnt_rd_q < k_used;
	assign s_take = s_elig && (s_inf ? (!found_inf_q || age_gt)
		: (!found_inf_q && (!found_q || age_gt)));

	logic [CW-1:0] cur_n;
	logic full_access;
	assign cur_n = tracked_q[fidx] ? cnt_rd_q : '0;
	assign full_access = (CW+1)'(cur_n) + 1'b1 > (CW+1)'(k_used);

	assign in_ch.ready = state_q == S_IDLE;
	assign out_ch.valid = state_q == S_DONE;
	assign out_ch.victim_valid = res_vv_q;
	assign out_ch.chosen_frame = res_vf_q;
	assign out_ch.status = res_st_q;
	assign out_ch.evictable_count = total_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_ch.valid) state_d = (cmd_t'(in_ch.cmd) == CMD_EVICT)
				? S_SCAN_RD : S_SHIFT_RD;
			S_SHIFT_RD: begin
				if (cmd_t'(cmd_q) != CMD_ACCESS || !in_range || !full_access
					|| 32'(pos_q) + 1 >= 32'(cur_n)) state_d = S_DONE;
				else state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: state_d = (32'(idx_q) + 1 >= FRAME_COUNT) ? S_DONE : S_SCAN_RD;
			S_DONE: if (out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic [FW+HW-1:0] rd_addr;
	always_comb begin
		if (state_q == S_SCAN_RD) rd_addr = (FW+HW)'(sidx) * (FW+HW)'(MAX_HISTORY);
		else rd_addr = (FW+HW)'(fidx) * (FW+HW)'(MAX_HISTORY) + (FW+HW)'(pos_q) + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SHIFT_RD || state_q == S_SCAN_RD) rd_q <= hist_mem[rd_addr];
		if (state_q == S_SHIFT_WR)
			hist_mem[(FW+HW)'(fidx) * (FW+HW)'(MAX_HISTORY) + (FW+HW)'(pos_q)] <= rd_q;
		else if (state_q == S_SHIFT_RD && state_d == S_DONE
			&& cmd_t'(cmd_q) == CMD_ACCESS && in_range)
			hist_mem[(FW+HW)'(fidx) * (FW+HW)'(MAX_HISTORY)
				+ (full_access ? (FW+HW)'(cur_n) - 1'b1 : (FW+HW)'(cur_n))] <= clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= 4'd2;
			tracked_q <= '0;
			evict_q <= '0;
			for (int i = 0; i < FRAME_COUNT; i++) cnt_q[i] <= '0;
			cnt_rd_q <= '0;
			clock_q <= '0;
			total_q <= '0;
			cmd_q <= '0;
			frame_in_q <= '0;
			flag_q <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			found_inf_q <= 1'b0;
			best_q <= '0;
			best_f_q <= '0;
			res_vv_q <= 1'b0;
			res_vf_q <= '0;
			res_st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (cfg_we) depth_q <= cfg_data;
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					cmd_q <= in_ch.cmd;
					frame_in_q <= in_ch.frame;
					flag_q <= in_ch.evictable_flag;
					cnt_rd_q <= cnt_q[FW'(in_ch.frame)];
					idx_q <= '0;
					pos_q <= '0;
					found_q <= 1'b0;
					found_inf_q <= 1'b0;
					best_q <= '0;
					best_f_q <= '0;
				end
				S_SHIFT_WR: pos_q <= pos_q + 1'b1;
				S_SHIFT_RD: if (state_d == S_DONE) begin
					res_vv_q <= 1'b0;
					res_vf_q <= '0;
					res_st_q <= (in_range && cmd_t'(cmd_q) == CMD_REMOVE
						&& tracked_q[fidx] && !evict_q[fidx]) ? ST_NOT_EVICTABLE : ST_OK;
					if (in_range) begin
						case (cmd_t'(cmd_q))
							CMD_ACCESS: begin
								tracked_q[fidx] <= 1'b1;
								if (!tracked_q[fidx]) evict_q[fidx] <= 1'b0;
								cnt_q[fidx] <= full_access ? cur_n : cur_n + 1'b1;
								clock_q <= clock_q + 1'b1;
							end
							CMD_SET_EVICT: if (tracked_q[fidx]) begin
								if (evict_q[fidx] && !flag_q) total_q <= total_q - 1'b1;
								else if (!evict_q[fidx] && flag_q) total_q <= total_q + 1'b1;
								evict_q[fidx] <= flag_q;
							end
							CMD_REMOVE: if (tracked_q[fidx] && evict_q[fidx]) begin
								total_q <= total_q - 1'b1;
								tracked_q[fidx] <= 1'b0;
								evict_q[fidx] <= 1'b0;
								cnt_q[fidx] <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN_RD: cnt_rd_q <= cnt_q[sidx];
				S_SCAN_CMP: begin
					if (s_take) begin
						best_q <= age;
						best_f_q <= sidx;
						found_q <= 1'b1;
						if (s_inf) found_inf_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (state_d == S_DONE) begin
						if (s_take || found_q) begin
							res_vv_q <= 1'b1;
							res_vf_q <= 6'(s_take ? sidx : best_f_q);
							res_st_q <= ST_OK;
							total_q <= total_q - 1'b1;
							tracked_q[s_take ? sidx : best_f_q] <= 1'b0;
							evict_q[s_take ? sidx : best_f_q] <= 1'b0;
							cnt_q[s_take ? sidx : best_f_q] <= '0;
						end else begin
							res_vv_q <= 1'b0;
							res_vf_q <= '0;
							res_st_q <= ST_NO_VICTIM;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/core/lruk_checker.sv]
// Port-level checker for the LRU-K frame replacer, bound to the top level.
// Depends on lruk_pkg and lru_k_frame_replacer.
module lruk_checker
	import lruk_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic victim_valid,
	input logic [5:0] chosen_frame,
	input logic [1:0] status
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input ready while result pending");
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_victim_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && victim_valid |-> status == ST_OK) else $error("victim with error");
	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !victim_valid |-> chosen_frame == 6'd0) else $error("stray victim");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind lru_k_frame_replacer lruk_checker u_lruk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.victim_valid(out_ch.victim_valid),
	.chosen_frame(out_ch.chosen_frame),
	.status(out_ch.status)
);

[tb/lru_k_frame_replacer_test.sv]
// Self-checking test of the LRU-K frame replacer: directed and random command words,
// predicted results checked word by word. Depends on lruk_pkg, lruk_if and the RTL.
module lru_k_frame_replacer_test;
	import lruk_pkg::*;

	typedef struct packed {
		logic victim_valid;
		logic [5:0] chosen_frame;
		status_t status;
		logic [6:0] evictable_count;
	} result_t;

	localparam int FRAMES = 64;
	localparam int HMAX = 8;
	localparam int IDLE_LIMIT = 20000;
	localparam int QDEPTH = 2048;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [3:0] cfg_data = 0;
	lruk_in_if in_ch ();
	lruk_out_if out_ch ();

	lru_k_frame_replacer dut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source));

	always #5 clk = ~clk;

	bit tracked [FRAMES];
	bit evictable [FRAMES];
	int unsigned hcount [FRAMES];
	logic [47:0] htimes [FRAMES][HMAX];
	logic [47:0] stamp;
	int unsigned evict_total;
	logic [3:0] depth_reg;
	result_t want_fifo [QDEPTH];
	int wr_ptr = 0;
	int rd_ptr = 0;
	int mismatches = 0;
	int words_sent = 0;
	int words_checked = 0;
	int victims_seen = 0;
	bit sender_idles = 1;
	bit receiver_idles = 1;
	bit hold_receiver = 0;
	int quiet_cycles = 0;

	function automatic int unsigned depth_k();
		if (depth_reg < 1) return 1;
		if (depth_reg > HMAX) return HMAX;
		return 32'(depth_reg);
	endfunction

	function automatic void drop_frame(int f);
		tracked[f] = 0;
		evictable[f] = 0;
		hcount[f] = 0;
	endfunction

	function automatic result_t replacer_predict(cmd_t cmd, int f, bit flag);
		result_t r;
		int unsigned k, n, v;
		bit found, found_inf, inf;
		logic [47:0] best, age;
		r = '0;
		r.status = ST_OK;
		k = depth_k();
		case (cmd)
			CMD_ACCESS: begin
				if (!tracked[f]) begin
					tracked[f] = 1;
					evictable[f] = 0;
					hcount[f] = 0;
				end
				n = hcount[f];
				if (n + 1 > k) begin
					for (int i = 1; i < n; i++) htimes[f][i-1] = htimes[f][i];
					htimes[f][n-1] = stamp;
				end else begin
					htimes[f][n] = stamp;
					hcount[f] = n + 1;
				end
				stamp = stamp + 1;
			end
			CMD_SET_EVICT: begin
				if (tracked[f]) begin
					if (evictable[f] && !flag) evict_total--;
					else if (!evictable[f] && flag) evict_total++;
					evictable[f] = flag;
				end
			end
			CMD_REMOVE: begin
				if (tracked[f]) begin
					if (!evictable[f]) r.status = ST_NOT_EVICTABLE;
					else begin
						evict_total--;
						drop_frame(f);
					end
				end
			end
			default: begin
				found = 0;
				found_inf = 0;
				best = 0;
				v = 0;
				for (int i = 0; i < FRAMES; i++) begin
					if (!tracked[i] || !evictable[i]) continue;
					age = stamp - htimes[i][0];
					inf = hcount[i] < k;
					if (inf) begin
						if (!found_inf || age > best) begin
							v = i;
							best = age;
							found = 1;
							found_inf = 1;
						end
					end else if (!found_inf && (!found || age > best)) begin
						v = i;
						best = age;
						found = 1;
					end
				end
				if (found) begin
					r.victim_valid = 1;
					r.chosen_frame = 6'(v);
					evict_total--;
					drop_frame(v);
				end else r.status = ST_NO_VICTIM;
			end
		endcase
		r.evictable_count = evict_total[6:0];
		return r;
	endfunction

	task automatic send_word(cmd_t cmd, int f, bit flag);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		want_fifo[wr_ptr % QDEPTH] = replacer_predict(cmd, f, flag);
		wr_ptr++;
		in_ch.valid <= 1;
		in_ch.cmd <= cmd;
		in_ch.frame <= 6'(f);
		in_ch.evictable_flag <= flag;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (wr_ptr != rd_ptr) @(posedge clk);
		repeat (2 * FRAMES + 2 * HMAX + 8) @(posedge clk);
	endtask

	task automatic write_depth(int unsigned value);
		cfg_we <= 1;
		cfg_data <= 4'(value);
		@(posedge clk);
		cfg_we <= 0;
		depth_reg = 4'(value);
	endtask

	always @(posedge clk) begin
		if (!arst_n || hold_receiver) out_ch.ready <= 0;
		else if (receiver_idles && $urandom_range(0, 5) == 0) begin
			out_ch.ready <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
			out_ch.ready <= 1;
		end else out_ch.ready <= 1;
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.victim_valid = out_ch.victim_valid;
			got.chosen_frame = out_ch.chosen_frame;
			got.status = status_t'(out_ch.status);
			got.evictable_count = out_ch.evictable_count;
			if (wr_ptr == rd_ptr) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %p", got);
			end else begin
				want = want_fifo[rd_ptr % QDEPTH];
				rd_ptr++;
				words_checked++;
				if (got.victim_valid) victims_seen++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IDLE_LIMIT) begin
			$display("lru_k_frame_replacer regression: fail");
			$finish;
		end
	end

	task automatic test_directed();
		send_word(CMD_EVICT, 0, 0);
		send_word(CMD_REMOVE, 5, 0);
		send_word(CMD_SET_EVICT, 5, 1);
		send_word(CMD_ACCESS, 0, 0);
		send_word(CMD_ACCESS, 63, 1);
		send_word(CMD_ACCESS, 0, 0);
		send_word(CMD_REMOVE, 0, 0);
		send_word(CMD_SET_EVICT, 0, 1);
		send_word(CMD_SET_EVICT, 63, 1);
		send_word(CMD_SET_EVICT, 63, 1);
		send_word(CMD_ACCESS, 0, 0);
		send_word(CMD_ACCESS, 0, 0);
		send_word(CMD_EVICT, 0, 0);
		send_word(CMD_SET_EVICT, 0, 0);
		send_word(CMD_EVICT, 0, 0);
		send_word(CMD_SET_EVICT, 0, 1);
		send_word(CMD_REMOVE, 0, 0);
		send_word(CMD_EVICT, 0, 0);
		drain();
	endtask

	task automatic test_random(int count, int span);
		int c, f;
		for (int i = 0; i < count; i++) begin
			c = $urandom_range(0, 9);
			f = (i % 97 == 0) ? ((i & 1) ? 63 : 0) : $urandom_range(0, span - 1);
			if (c < 5) send_word(CMD_ACCESS, f, 1'($urandom_range(0, 1)));
			else if (c < 7) send_word(CMD_SET_EVICT, f, $urandom_range(0, 3) != 0);
			else if (c < 8) send_word(CMD_REMOVE, f, 1'($urandom_range(0, 1)));
			else send_word(CMD_EVICT, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
		end
		drain();
	endtask

	task automatic test_depth_change();
		write_depth(1);
		test_random(150, 12);
		write_depth(8);
		test_random(150, 8);
		write_depth(3);
		test_random(150, 16);
		write_depth(0);
		test_random(100, 10);
		write_depth(15);
		test_random(100, 10);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_receiver = 1;
				repeat (300) @(posedge clk);
				hold_receiver = 0;
			end
			test_random(20, 64);
		join
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.cmd = CMD_ACCESS;
		in_ch.frame = 0;
		in_ch.evictable_flag = 0;
		out_ch.ready = 0;
		for (int i = 0; i < FRAMES; i++) drop_frame(i);
		stamp = 0;
		evict_total = 0;
		depth_reg = 2;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(350, 64);
		test_depth_change();
		test_backpressure();
		test_random(200, 20);
		sender_idles = 0;
		receiver_idles = 0;
		test_random(300, 64);
		$display("covered %0d words (%0d checked, %0d victims), depths 0,1,2,3,8,15",
			words_sent, words_checked, victims_seen);
		$display("including a long output stall and back-to-back traffic at the end");
		if (mismatches == 0 && wr_ptr == rd_ptr)
			$display("lru_k_frame_replacer regression: pass");
		else
			$display("lru_k_frame_replacer regression: fail");
		$finish;
	end
endmodule
